// File: design/sanb_pkg.sv
// shared types, constants and round / key schedule functions for the nibble cipher
// no dependencies; imported by every module of the block
package sanb_pkg;

  localparam int SANB_ROUNDS = 5;
  localparam int BLK_W       = 64;
  localparam int NIBS        = 16;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 64;

  // register index carried on the top address bit (8-byte spacing)
  localparam logic CFG_IDX_MASTER_KEY = 1'b0;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [3:0]       nib_t;

  // valid flag and direction of one pipeline stage
  typedef struct packed {
    logic valid;
    logic op;
  } stage_ctl_t;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam nib_t SBOX [NIBS] = '{
    4'h6, 4'hB, 4'h5, 4'h4, 4'h2, 4'hE, 4'h7, 4'hA,
    4'h9, 4'hD, 4'hF, 4'hC, 4'h3, 4'h1, 4'h0, 4'h8
  };
  localparam nib_t INV_SBOX [NIBS] = '{
    4'hE, 4'hD, 4'h4, 4'hC, 4'h3, 4'h2, 4'h0, 4'h6,
    4'hF, 4'h8, 4'h7, 4'h1, 4'hB, 4'h9, 4'h5, 4'hA
  };

  localparam nib_t FWD_COEF [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
  localparam nib_t INV_COEF [4] = '{4'hE, 4'hB, 4'hD, 4'h9};

  // nibble k sits at the most significant end for k = 0
  function automatic nib_t nib_get(blk_t x, int k);
    return x[BLK_W-1-4*k -: 4];
  endfunction

  // multiply by x modulo x^4+x+1
  function automatic nib_t xtime4(nib_t a);
    return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic nib_t gmul(nib_t a, nib_t b);
    nib_t r;
    nib_t t;
    r = '0;
    t = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ t;
      t = xtime4(t);
    end
    return r;
  endfunction

  // x^(r-1) for round key r
  function automatic nib_t rcon_of(int r);
    nib_t rc;
    rc = 4'h1;
    for (int i = 1; i < r; i++) rc = xtime4(rc);
    return rc;
  endfunction

  function automatic blk_t sub_all(blk_t x, logic inv);
    blk_t y;
    nib_t n;
    y = '0;
    for (int k = 0; k < NIBS; k++) begin
      n = nib_get(x, k);
      y[BLK_W-1-4*k -: 4] = inv ? INV_SBOX[n] : SBOX[n];
    end
    return y;
  endfunction

  // row r rotated left by r, or right by r for the inverse
  function automatic blk_t rot_rows(blk_t x, logic inv);
    blk_t y;
    int   src;
    y = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = 4 * ((c + (inv ? 3 : 1) * r) & 3) + r;
        y[BLK_W-1-4*(4*c+r) -: 4] = nib_get(x, src);
      end
    end
    return y;
  endfunction

  function automatic blk_t mix_cols(blk_t x, logic inv);
    blk_t y;
    nib_t acc;
    y = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
          acc = acc ^ gmul(nib_get(x, 4*c + ((r + j) & 3)),
                           inv ? INV_COEF[j] : FWD_COEF[j]);
        end
        y[BLK_W-1-4*(4*c+r) -: 4] = acc;
      end
    end
    return y;
  endfunction

  // one step of the key schedule
  function automatic blk_t key_step(blk_t prev, nib_t rc);
    nib_t t   [4];
    nib_t cur [NIBS];
    blk_t y;
    for (int i = 0; i < 4; i++) t[i] = SBOX[nib_get(prev, 12 + ((i + 1) & 3))];
    t[0] = t[0] ^ rc;
    for (int i = 0; i < 4; i++) cur[i] = nib_get(prev, i) ^ t[i];
    for (int c = 1; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        cur[4*c+i] = nib_get(prev, 4*c+i) ^ cur[4*(c-1)+i];
      end
    end
    y = '0;
    for (int k = 0; k < NIBS; k++) y[BLK_W-1-4*k -: 4] = cur[k];
    return y;
  endfunction

endpackage

// File: design/small_aes_nibble_block_cipher.sv
// small-scale aes on 64-bit nibble blocks: input whitening stage, round cell chain,
// key schedule chain and apb key register; depends on sanb_pkg, sanb_round_cell, sanb_key_cell
//
// usage:
//   input channel (in_valid/in_ready) takes one request per cycle while in_ready is high:
//   in_operation selects encrypt (0) or decrypt (1), in_block is the 64-bit block.
//   output channel (out_valid/out_ready) returns out_block in request order.
//   the pipeline is one whitening stage plus one round cell per round, each cell a
//   register stage; throughput is one block per cycle while no stage stalls and keys are settled.
//   the apb port holds the 64-bit master key at address 0. after a key write, and
//   after reset, the round key chain settles one key cell after another, and in_ready
//   stays low until the settle counter has run down to zero.
//   reset clears all stage valids and the master key; keys are then re-expanded.
//   when the receiver stalls, the chain holds; empty stages still fill, so new
//   requests are taken until every stage is occupied.
module small_aes_nibble_block_cipher import sanb_pkg::*; #(
  parameter int ROUNDS = SANB_ROUNDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [BLK_W-1:0]  in_block,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BLK_W-1:0]  out_block,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(ROUNDS + 1);

  blk_t             master_key_r;
  logic [CNT_W-1:0] key_cnt_r;
  logic [CNT_W-1:0] key_cnt_nxt;
  logic             key_wr;

  blk_t             rk      [ROUNDS+1];
  stage_ctl_t       st_ctl  [ROUNDS+1];
  blk_t             st_data [ROUNDS+1];
  logic             st_rdy  [ROUNDS+2];

  stage_ctl_t       ctl0_r;
  blk_t             data0_r;
  stage_ctl_t       in_ctl;
  logic             st0_adv;

  // apb key register
  assign cfg_pready = 1'b1;
  assign key_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1] == CFG_IDX_MASTER_KEY);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == CFG_IDX_MASTER_KEY) ? master_key_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_key_r <= '0;
    end else if (key_wr) begin
      master_key_r <= cfg_pwdata;
    end
  end

  // settle counter for the key chain
  always_comb begin
    key_cnt_nxt = key_cnt_r;
    if (key_wr) begin
      key_cnt_nxt = CNT_W'(ROUNDS);
    end else if (key_cnt_r != '0) begin
      key_cnt_nxt = key_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cnt_r <= CNT_W'(ROUNDS);
    end else begin
      key_cnt_r <= key_cnt_nxt;
    end
  end

  assign rk[0] = master_key_r;

  for (genvar j = 1; j <= ROUNDS; j++) begin : g_key
    sanb_key_cell #(
      .RCON (rcon_of(j))
    ) u_key (
      .clk      (clk),
      .prev_key (rk[j-1]),
      .next_key (rk[j])
    );
  end

  // whitening stage
  assign st0_adv  = !ctl0_r.valid || st_rdy[1];
  assign in_ready = st0_adv && (key_cnt_r == '0);
  assign in_ctl   = '{valid: in_valid && in_ready, op: in_operation};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (st0_adv) begin
      ctl0_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data0_r <= in_block ^ ((in_operation == OP_DEC) ? rk[ROUNDS] : rk[0]);
    end
  end

  assign st_ctl[0]      = ctl0_r;
  assign st_data[0]     = data0_r;
  assign st_rdy[0]      = st0_adv;
  assign st_rdy[ROUNDS+1] = out_ready;

  for (genvar i = 1; i <= ROUNDS; i++) begin : g_round
    sanb_round_cell #(
      .LAST_ROUND (i == ROUNDS)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (st_ctl[i-1]),
      .up_data  (st_data[i-1]),
      .up_ready (st_rdy[i]),
      .enc_key  (rk[i]),
      .dec_key  (rk[ROUNDS-i]),
      .dn_ctl   (st_ctl[i]),
      .dn_data  (st_data[i]),
      .dn_ready (st_rdy[i+1])
    );
  end

  assign out_valid = st_ctl[ROUNDS].valid;
  assign out_block = st_data[ROUNDS];

`ifndef SYNTHESIS
  a_no_req_while_keys_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (key_cnt_r != '0) |-> !in_ready)
    else $error("request taken while round keys settle");

  a_key_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> (!in_ready && (key_cnt_r == CNT_W'(ROUNDS))))
    else $error("key write did not restart key settling");

  a_req_enters_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ctl0_r.valid)
    else $error("accepted request lost at whitening stage");

  a_stalled_stage0_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl0_r.valid && !st_rdy[1]) |=> (ctl0_r.valid && $stable(data0_r)))
    else $error("stalled whitening stage changed");
`endif

endmodule

// File: design/sanb_key_cell.sv
// one step of the round key chain: registers the next round key from the previous one
// depends on sanb_pkg (key_step)
module sanb_key_cell import sanb_pkg::*; #(
  parameter nib_t RCON = 4'h1
) (
  input  logic clk,
  input  blk_t prev_key,
  output blk_t next_key
);

  blk_t key_r;
  blk_t key_nxt;

  assign key_nxt  = key_step(prev_key, RCON);
  assign next_key = key_r;

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: design/sanb_round_cell.sv
// one cipher round with its stage register, for both directions
// depends on sanb_pkg (round functions, stage_ctl_t)
module sanb_round_cell import sanb_pkg::*; #(
  parameter bit LAST_ROUND = 1'b0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t up_ctl,
  input  blk_t       up_data,
  output logic       up_ready,
  input  blk_t       enc_key,
  input  blk_t       dec_key,
  output stage_ctl_t dn_ctl,
  output blk_t       dn_data,
  input  logic       dn_ready
);

  stage_ctl_t ctl_r;
  blk_t       data_r;
  blk_t       data_nxt;
  blk_t       enc_s;
  blk_t       dec_s;

  always_comb begin
    enc_s = rot_rows(sub_all(up_data, OP_ENC), OP_ENC);
    if (!LAST_ROUND) enc_s = mix_cols(enc_s, OP_ENC);
    enc_s = enc_s ^ enc_key;

    // inverse round adds the key before unmixing
    dec_s = rot_rows(sub_all(up_data, OP_DEC), OP_DEC) ^ dec_key;
    if (!LAST_ROUND) dec_s = mix_cols(dec_s, OP_DEC);

    data_nxt = (up_ctl.op == OP_DEC) ? dec_s : enc_s;
  end

  assign up_ready = !ctl_r.valid || dn_ready;
  assign dn_ctl   = ctl_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
